@@ sv/rrr_pkg.sv @@
// ---------------------------------------------------------------------------
// rrr_pkg
// Shared types, latencies and helpers for the radial reprojection residual.
// ---------------------------------------------------------------------------
`default_nettype none

package rrr_pkg;

  // stage counts of each unit
  localparam int FRONT_LAT = 8;
  localparam int SQRT_LAT  = 32;
  localparam int QBITS     = 31;
  localparam int DIV_LAT   = QBITS;
  localparam int LOG_FRAC  = 20;
  localparam int LOG_LAT   = 3 + LOG_FRAC + 1;
  localparam int LAM_DLY   = DIV_LAT - LOG_LAT;
  localparam int TAIL_LAT  = 7;
  localparam int TOTAL_LAT = FRONT_LAT + SQRT_LAT + DIV_LAT + TAIL_LAT;

  // register indexes
  localparam logic REG_CENTER_U = 1'b0;
  localparam logic REG_CENTER_V = 1'b1;

  // ln 2 in Q32, rounded
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  // front end result: squared norms, scaled components, offset point
  typedef struct packed {
    logic [62:0]        nsq;
    logic [30:0]        ra;
    logic [30:0]        rb;
    logic               sa;
    logic               sb;
    logic [62:0]        rsq;
    logic [1:0]         s2;
    logic signed [32:0] xcu;
    logic signed [32:0] xcv;
  } front_t;

  // carried alongside the square roots
  typedef struct packed {
    logic [30:0]        ra;
    logic [30:0]        rb;
    logic               sa;
    logic               sb;
    logic [1:0]         s2;
    logic signed [32:0] xcu;
    logic signed [32:0] xcv;
  } side_a_t;

  // carried alongside the dividers
  typedef struct packed {
    logic               sa;
    logic               sb;
    logic               degen;
    logic signed [32:0] xcu;
    logic signed [32:0] xcv;
  } side_b_t;

  // saturate to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) r = 32'sh7fffffff;
    else if (v < -48'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/rrr_front.sv @@
// ---------------------------------------------------------------------------
// rrr_front
// Rotation, translation, range scaling and squared norms, eight stages.
// ---------------------------------------------------------------------------
`default_nettype none

module rrr_front (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [31:0] img_u,
  input  wire logic signed [31:0] img_v,
  input  wire logic signed [31:0] pt_x,
  input  wire logic signed [31:0] pt_y,
  input  wire logic signed [31:0] pt_z,
  input  wire logic signed [31:0] quat_x,
  input  wire logic signed [31:0] quat_y,
  input  wire logic signed [31:0] quat_z,
  input  wire logic signed [31:0] quat_w,
  input  wire logic signed [31:0] shift_x,
  input  wire logic signed [31:0] shift_y,
  input  wire logic signed [31:0] center_u,
  input  wire logic signed [31:0] center_v,
  output rrr_pkg::front_t         fo
);
  import rrr_pkg::*;

  localparam logic signed [47:0] ONE_Q30 = 48'sd1073741824;

  function automatic logic signed [34:0] twice_q30(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return signed'(p[63:29]);
  endfunction

  function automatic logic signed [33:0] mul_q30(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return signed'(p[63:30]);
  endfunction

  // stage 1
  logic signed [34:0] xx1, yy1, zz1, xy1, xz1, yz1, wx1, wy1, wz1;
  logic signed [31:0] px1, py1, pz1, tx1, ty1;
  logic signed [32:0] xcu1, xcv1;
  // stage 2
  logic signed [31:0] r00, r01, r02, r10, r11, r12;
  logic signed [31:0] px2, py2, pz2, tx2, ty2;
  logic signed [32:0] xcu2, xcv2;
  logic [32:0]        cu2, cv2;
  // stage 3
  logic signed [33:0] p00, p01, p02, p10, p11, p12;
  logic signed [31:0] tx3, ty3;
  logic signed [32:0] xcu3, xcv3;
  logic [30:0]        rcu3, rcv3;
  logic [1:0]         s2_3;
  // stage 4
  logic signed [35:0] a4, b4;
  logic signed [32:0] xcu4, xcv4;
  logic [61:0]        squ4, sqv4;
  logic [1:0]         s2_4;
  // stage 5
  logic [35:0]        ua5, ub5;
  logic               sa5, sb5;
  logic signed [32:0] xcu5, xcv5;
  logic [62:0]        rsq5;
  logic [1:0]         s2_5;
  // stage 6
  logic [30:0]        ra6, rb6;
  logic               sa6, sb6;
  logic signed [32:0] xcu6, xcv6;
  logic [62:0]        rsq6;
  logic [1:0]         s2_6;
  // stage 7
  logic [61:0]        sqa7, sqb7;
  logic [30:0]        ra7, rb7;
  logic               sa7, sb7;
  logic signed [32:0] xcu7, xcv7;
  logic [62:0]        rsq7;
  logic [1:0]         s2_7;

  // range shifts
  logic [32:0] or33;
  logic [1:0]  s2_next;
  logic [35:0] or36;
  logic [2:0]  s_next;

  always_comb begin
    or33 = cu2 | cv2;
    if (or33[32]) s2_next = 2'd2;
    else if (or33[31]) s2_next = 2'd1;
    else s2_next = 2'd0;
    or36 = ua5 | ub5;
    s_next = 3'd0;
    for (int i = 1; i <= 5; i++) begin
      if (or36[30+i]) s_next = 3'(i);
    end
  end

  // stage 1: doubled quaternion products, offset image point
  always_ff @(posedge clk) begin
    if (en) begin
      xx1  <= twice_q30(quat_x, quat_x);
      yy1  <= twice_q30(quat_y, quat_y);
      zz1  <= twice_q30(quat_z, quat_z);
      xy1  <= twice_q30(quat_x, quat_y);
      xz1  <= twice_q30(quat_x, quat_z);
      yz1  <= twice_q30(quat_y, quat_z);
      wx1  <= twice_q30(quat_w, quat_x);
      wy1  <= twice_q30(quat_w, quat_y);
      wz1  <= twice_q30(quat_w, quat_z);
      px1  <= pt_x;
      py1  <= pt_y;
      pz1  <= pt_z;
      tx1  <= shift_x;
      ty1  <= shift_y;
      xcu1 <= 33'(img_u) - 33'(center_u);
      xcv1 <= 33'(img_v) - 33'(center_v);
    end
  end

  // stage 2: two rows of the rotation matrix, magnitudes of the offset
  always_ff @(posedge clk) begin
    if (en) begin
      r00  <= sat32(ONE_Q30 - (48'(yy1) + 48'(zz1)));
      r01  <= sat32(48'(xy1) - 48'(wz1));
      r02  <= sat32(48'(xz1) + 48'(wy1));
      r10  <= sat32(48'(xy1) + 48'(wz1));
      r11  <= sat32(ONE_Q30 - (48'(xx1) + 48'(zz1)));
      r12  <= sat32(48'(yz1) - 48'(wx1));
      px2  <= px1;
      py2  <= py1;
      pz2  <= pz1;
      tx2  <= tx1;
      ty2  <= ty1;
      xcu2 <= xcu1;
      xcv2 <= xcv1;
      cu2  <= xcu1[32] ? 33'(-xcu1) : 33'(xcu1);
      cv2  <= xcv1[32] ? 33'(-xcv1) : 33'(xcv1);
    end
  end

  // stage 3: matrix times point, offset scaled below 2^31
  always_ff @(posedge clk) begin
    if (en) begin
      p00  <= mul_q30(r00, px2);
      p01  <= mul_q30(r01, py2);
      p02  <= mul_q30(r02, pz2);
      p10  <= mul_q30(r10, px2);
      p11  <= mul_q30(r11, py2);
      p12  <= mul_q30(r12, pz2);
      tx3  <= tx2;
      ty3  <= ty2;
      xcu3 <= xcu2;
      xcv3 <= xcv2;
      rcu3 <= 31'(cu2 >> s2_next);
      rcv3 <= 31'(cv2 >> s2_next);
      s2_3 <= s2_next;
    end
  end

  // stage 4: row sums plus translation, squares of the offset
  always_ff @(posedge clk) begin
    if (en) begin
      a4   <= 36'(p00) + 36'(p01) + 36'(p02) + 36'(tx3);
      b4   <= 36'(p10) + 36'(p11) + 36'(p12) + 36'(ty3);
      squ4 <= rcu3 * rcu3;
      sqv4 <= rcv3 * rcv3;
      xcu4 <= xcu3;
      xcv4 <= xcv3;
      s2_4 <= s2_3;
    end
  end

  // stage 5: magnitudes and signs, offset squared norm
  always_ff @(posedge clk) begin
    if (en) begin
      ua5  <= a4[35] ? 36'(-a4) : 36'(a4);
      ub5  <= b4[35] ? 36'(-b4) : 36'(b4);
      sa5  <= a4[35];
      sb5  <= b4[35];
      rsq5 <= 63'(squ4) + 63'(sqv4);
      xcu5 <= xcu4;
      xcv5 <= xcv4;
      s2_5 <= s2_4;
    end
  end

  // stage 6: scale the vector below 2^31
  always_ff @(posedge clk) begin
    if (en) begin
      ra6  <= 31'(ua5 >> s_next);
      rb6  <= 31'(ub5 >> s_next);
      sa6  <= sa5;
      sb6  <= sb5;
      rsq6 <= rsq5;
      xcu6 <= xcu5;
      xcv6 <= xcv5;
      s2_6 <= s2_5;
    end
  end

  // stage 7: squares
  always_ff @(posedge clk) begin
    if (en) begin
      sqa7 <= ra6 * ra6;
      sqb7 <= rb6 * rb6;
      ra7  <= ra6;
      rb7  <= rb6;
      sa7  <= sa6;
      sb7  <= sb6;
      rsq7 <= rsq6;
      xcu7 <= xcu6;
      xcv7 <= xcv6;
      s2_7 <= s2_6;
    end
  end

  // stage 8: squared norm of the vector
  always_ff @(posedge clk) begin
    if (en) begin
      fo.nsq <= 63'(sqa7) + 63'(sqb7);
      fo.ra  <= ra7;
      fo.rb  <= rb7;
      fo.sa  <= sa7;
      fo.sb  <= sb7;
      fo.rsq <= rsq7;
      fo.s2  <= s2_7;
      fo.xcu <= xcu7;
      fo.xcv <= xcv7;
    end
  end

endmodule

`default_nettype wire

@@ sv/rrr_isqrt.sv @@
// ---------------------------------------------------------------------------
// rrr_isqrt
// Floor integer square root of a 63-bit value, one result bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module rrr_isqrt (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [62:0] val,
  output logic      [31:0] root
);
  import rrr_pkg::*;

  logic [63:0] rem_q [SQRT_LAT];
  logic [63:0] res_q [SQRT_LAT];

  for (genvar j = 0; j < SQRT_LAT; j++) begin : g_st
    logic [63:0] r_in, s_in, bit_c, trial;
    if (j == 0) begin : g_first
      assign r_in = {1'b0, val};
      assign s_in = '0;
    end else begin : g_rest
      assign r_in = rem_q[j-1];
      assign s_in = res_q[j-1];
    end
    assign bit_c = 64'(1) << (62 - 2*j);
    assign trial = s_in + bit_c;

    // one restoring step
    always_ff @(posedge clk) begin
      if (en) begin
        if (r_in >= trial) begin
          rem_q[j] <= r_in - trial;
          res_q[j] <= (s_in >> 1) + bit_c;
        end else begin
          rem_q[j] <= r_in;
          res_q[j] <= s_in >> 1;
        end
      end
    end
  end

  assign root = res_q[SQRT_LAT-1][31:0];

endmodule

`default_nettype wire

@@ sv/rrr_div.sv @@
// ---------------------------------------------------------------------------
// rrr_div
// Pipelined restoring divider: (num << 30) / den, one quotient bit a stage.
// ---------------------------------------------------------------------------
`default_nettype none

module rrr_div (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [30:0] num,
  input  wire logic [31:0] den,
  output logic      [30:0] quo
);
  import rrr_pkg::*;

  logic [62:0]      rem_q [DIV_LAT];
  logic [QBITS-1:0] quo_q [DIV_LAT];
  logic [31:0]      den_q [DIV_LAT];

  for (genvar j = 0; j < DIV_LAT; j++) begin : g_st
    logic [62:0]      r_in, dsh;
    logic [QBITS-1:0] q_in;
    logic [31:0]      d_in;
    if (j == 0) begin : g_first
      assign r_in = {2'b0, num, 30'b0};
      assign q_in = '0;
      assign d_in = den;
    end else begin : g_rest
      assign r_in = rem_q[j-1];
      assign q_in = quo_q[j-1];
      assign d_in = den_q[j-1];
    end
    assign dsh = 63'(d_in) << (QBITS - 1 - j);

    // trial subtract of the shifted divisor
    always_ff @(posedge clk) begin
      if (en) begin
        den_q[j] <= d_in;
        if (r_in >= dsh) begin
          rem_q[j] <= r_in - dsh;
          quo_q[j] <= q_in | (QBITS'(1) << (QBITS - 1 - j));
        end else begin
          rem_q[j] <= r_in;
          quo_q[j] <= q_in;
        end
      end
    end
  end

  assign quo = quo_q[DIV_LAT-1];

endmodule

`default_nettype wire

@@ sv/rrr_log.sv @@
// ---------------------------------------------------------------------------
// rrr_log
// lambda = ln(1 + radius) in Q16, log2 by repeated squaring, one bit a stage.
// ---------------------------------------------------------------------------
`default_nettype none

module rrr_log (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [33:0] rad,
  output logic      [20:0] lam
);
  import rrr_pkg::*;

  logic [34:0] y1, y2;
  logic [5:0]  k2, k3, k_next;
  logic [30:0] m3;
  logic [30:0]         m_q    [LOG_FRAC];
  logic [LOG_FRAC-1:0] frac_q [LOG_FRAC];
  logic [5:0]          k_q    [LOG_FRAC];
  logic [56:0] prod;
  logic [4:0]  kint;

  // top set bit
  always_comb begin
    k_next = '0;
    for (int i = 0; i < 35; i++) begin
      if (y1[i]) k_next = 6'(i);
    end
  end

  // Y, its top bit, mantissa aligned to Q30
  always_ff @(posedge clk) begin
    if (en) begin
      y1 <= 35'(rad) + 35'd65536;
      y2 <= y1;
      k2 <= k_next;
      m3 <= 31'({y2, 30'b0} >> k2);
      k3 <= k2;
    end
  end

  for (genvar j = 0; j < LOG_FRAC; j++) begin : g_sq
    logic [30:0]         m_in;
    logic [LOG_FRAC-1:0] f_in;
    logic [5:0]          k_in;
    logic [61:0]         sq;
    logic [31:0]         t;
    if (j == 0) begin : g_first
      assign m_in = m3;
      assign f_in = '0;
      assign k_in = k3;
    end else begin : g_rest
      assign m_in = m_q[j-1];
      assign f_in = frac_q[j-1];
      assign k_in = k_q[j-1];
    end
    assign sq = m_in * m_in;
    assign t  = sq[61:30];

    // square; a carry into bit 31 gives the next fraction bit
    always_ff @(posedge clk) begin
      if (en) begin
        k_q[j] <= k_in;
        if (t[31]) begin
          m_q[j]    <= t[31:1];
          frac_q[j] <= f_in | (LOG_FRAC'(1) << (LOG_FRAC - 1 - j));
        end else begin
          m_q[j]    <= t[30:0];
          frac_q[j] <= f_in;
        end
      end
    end
  end

  // log2 in Q20 times ln 2
  assign kint = 5'(k_q[LOG_FRAC-1] - 6'd16);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= 57'({kint, frac_q[LOG_FRAC-1]}) * 57'(LN2_Q32);
    end
  end

  assign lam = prod[56:36];

endmodule

`default_nettype wire

@@ sv/rrr_tail.sv @@
// ---------------------------------------------------------------------------
// rrr_tail
// Direction signs, projection onto the direction, weighting and saturation.
// ---------------------------------------------------------------------------
`default_nettype none

module rrr_tail (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [30:0]        qu,
  input  wire logic [30:0]        qv,
  input  rrr_pkg::side_b_t        sb_in,
  input  wire logic [20:0]        lam_in,
  output logic signed [31:0]      res_u,
  output logic signed [31:0]      res_v,
  output logic                    degenerate
);
  import rrr_pkg::*;

  logic signed [31:0] zu0, zv0, zu1, zv1, zu2, zv2;
  logic signed [32:0] xcu0, xcv0, xcu1, xcv1, xcu2, xcv2, xcu3, xcv3;
  logic [20:0]        lam0, lam1, lam2, lam3, lam4, lam5;
  logic               dg0, dg1, dg2, dg3, dg4, dg5;
  logic signed [64:0] pu1, pv1;
  logic signed [34:0] al2;
  logic signed [66:0] mu3, mv3;
  logic signed [35:0] du4, dv4;
  logic signed [57:0] ru5, rv5;
  logic signed [65:0] dot;

  assign dot = 66'(pu1) + 66'(pv1);

  always_ff @(posedge clk) begin
    if (en) begin
      // signed direction, zero when degenerate
      if (sb_in.degen) begin
        zu0 <= '0;
        zv0 <= '0;
      end else begin
        zu0 <= sb_in.sa ? -$signed({1'b0, qu}) : $signed({1'b0, qu});
        zv0 <= sb_in.sb ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
      end
      xcu0 <= sb_in.xcu;
      xcv0 <= sb_in.xcv;
      lam0 <= lam_in;
      dg0  <= sb_in.degen;
      // products for the dot product
      pu1  <= zu0 * xcu0;
      pv1  <= zv0 * xcv0;
      zu1  <= zu0;
      zv1  <= zv0;
      xcu1 <= xcu0;
      xcv1 <= xcv0;
      lam1 <= lam0;
      dg1  <= dg0;
      // alpha
      al2  <= signed'(dot[64:30]);
      zu2  <= zu1;
      zv2  <= zv1;
      xcu2 <= xcu1;
      xcv2 <= xcv1;
      lam2 <= lam1;
      dg2  <= dg1;
      // alpha times direction
      mu3  <= al2 * zu2;
      mv3  <= al2 * zv2;
      xcu3 <= xcu2;
      xcv3 <= xcv2;
      lam3 <= lam2;
      dg3  <= dg2;
      // difference
      du4  <= signed'(mu3[65:30]) - 36'(xcu3);
      dv4  <= signed'(mv3[65:30]) - 36'(xcv3);
      lam4 <= lam3;
      dg4  <= dg3;
      // weighting
      ru5  <= $signed({1'b0, lam4}) * du4;
      rv5  <= $signed({1'b0, lam4}) * dv4;
      dg5  <= dg4;
      // output word
      res_u      <= sat32(48'(signed'(ru5[57:16])));
      res_v      <= sat32(48'(signed'(rv5[57:16])));
      degenerate <= dg5;
    end
  end

endmodule

`default_nettype wire

@@ sv/radial_reprojection_residual.sv @@
// ---------------------------------------------------------------------------
// radial_reprojection_residual
// Weighted radial reprojection residual of one correspondence per word.
// ---------------------------------------------------------------------------
//  channel  handshake            payload
//  input    in_valid / in_stall  img_u..shift_y, eleven 32-bit fields
//  output   out_valid/ out_stall res_u, res_v, degenerate
//  config   cfg_wen              cfg_index, cfg_data (center_u, center_v)
//
//  One word enters per cycle while the output is not stalled; it passes the
//  front end, both 32-stage root units, the 31-stage dividers and the tail.
//  Reset clears the valid line and both centre registers.
//  A stalled output word freezes the whole pipeline; nothing is dropped.
// ---------------------------------------------------------------------------
`default_nettype none

module radial_reprojection_residual (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] img_u,
  input  wire logic signed [31:0] img_v,
  input  wire logic signed [31:0] pt_x,
  input  wire logic signed [31:0] pt_y,
  input  wire logic signed [31:0] pt_z,
  input  wire logic signed [31:0] quat_x,
  input  wire logic signed [31:0] quat_y,
  input  wire logic signed [31:0] quat_z,
  input  wire logic signed [31:0] quat_w,
  input  wire logic signed [31:0] shift_x,
  input  wire logic signed [31:0] shift_y,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      res_u,
  output logic signed [31:0]      res_v,
  output logic                    degenerate,
  input  wire logic               cfg_wen,
  input  wire logic               cfg_index,
  input  wire logic [31:0]        cfg_data
);
  import rrr_pkg::*;

  logic signed [31:0] center_u, center_v;
  logic               en;
  logic [TOTAL_LAT-1:0] vld;
  front_t  fo;
  side_a_t da [SQRT_LAT];
  side_b_t db [DIV_LAT];
  logic [20:0] dl [LAM_DLY];
  logic [31:0] norm, root2;
  logic [33:0] rad;
  logic        degen;
  logic [30:0] qu, qv;
  logic [20:0] lam;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center_u <= '0;
      center_v <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_CENTER_U: center_u <= cfg_data;
        REG_CENTER_V: center_v <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance
  assign en       = !(out_valid && out_stall);
  assign in_stall = rst || (out_valid && out_stall);
  assign out_valid = vld[TOTAL_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[TOTAL_LAT-2:0], in_valid};
  end

  rrr_front u_front (
    .clk, .en, .img_u, .img_v, .pt_x, .pt_y, .pt_z,
    .quat_x, .quat_y, .quat_z, .quat_w, .shift_x, .shift_y,
    .center_u, .center_v, .fo
  );

  rrr_isqrt u_norm (.clk, .en, .val(fo.nsq), .root(norm));
  rrr_isqrt u_rad  (.clk, .en, .val(fo.rsq), .root(root2));

  // side data beside the root units
  always_ff @(posedge clk) begin
    if (en) begin
      da[0] <= '{ra: fo.ra, rb: fo.rb, sa: fo.sa, sb: fo.sb, s2: fo.s2,
                 xcu: fo.xcu, xcv: fo.xcv};
      for (int i = 1; i < SQRT_LAT; i++) da[i] <= da[i-1];
    end
  end

  assign degen = (norm == '0);
  assign rad   = 34'(root2) << da[SQRT_LAT-1].s2;

  rrr_div u_div_u (.clk, .en, .num(da[SQRT_LAT-1].ra), .den(norm), .quo(qu));
  rrr_div u_div_v (.clk, .en, .num(da[SQRT_LAT-1].rb), .den(norm), .quo(qv));
  rrr_log u_log   (.clk, .en, .rad, .lam);

  // side data beside the dividers, lambda aligned to them
  always_ff @(posedge clk) begin
    if (en) begin
      db[0] <= '{sa: da[SQRT_LAT-1].sa, sb: da[SQRT_LAT-1].sb, degen: degen,
                 xcu: da[SQRT_LAT-1].xcu, xcv: da[SQRT_LAT-1].xcv};
      for (int i = 1; i < DIV_LAT; i++) db[i] <= db[i-1];
      dl[0] <= lam;
      for (int i = 1; i < LAM_DLY; i++) dl[i] <= dl[i-1];
    end
  end

  rrr_tail u_tail (
    .clk, .en, .qu, .qv, .sb_in(db[DIV_LAT-1]), .lam_in(dl[LAM_DLY-1]),
    .res_u, .res_v, .degenerate
  );

`ifndef SYNTHESIS
  // a held pipeline keeps its valid line
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> (vld == $past(vld)))
    else $error("valid line moved while the pipeline was held");

  // an accepted word enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> vld[0])
    else $error("accepted word not captured");

  // no output word straight after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word valid after reset");
`endif

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Streams correspondences through the residual pipeline under random gaps
// and output back-pressure, predicts every word and compares all fields.
// ---------------------------------------------------------------------------

module testbench;
  import rrr_pkg::*;

  // one correspondence word
  typedef struct {
    logic signed [31:0] f [11];
  } corr_t;

  // expected residual word
  typedef struct {
    logic signed [31:0] ru;
    logic signed [31:0] rv;
    logic               dg;
  } resid_t;

  class residual_scoreboard;
    logic signed [63:0] cu, cv;
    resid_t pending [$];
    int     errors;

    function new();
      cu = 0;
      cv = 0;
      errors = 0;
    endfunction

    function void set_centre(logic idx, logic [31:0] d);
      if (idx == REG_CENTER_U) cu = $signed(d);
      else cv = $signed(d);
    endfunction

    // floor shift on signed 128-bit
    function logic signed [127:0] fsr(logic signed [127:0] v, int s);
      return v >>> s;
    endfunction

    function logic signed [31:0] clamp(logic signed [127:0] v);
      if (v > 128'sd2147483647) return 32'sh7fffffff;
      if (v < -128'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    function logic [63:0] root(logic [63:0] n);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else r >>= 1;
        b >>= 2;
      end
      return r;
    endfunction

    function int scale31(logic [63:0] a, logic [63:0] b);
      int s;
      s = 0;
      while ((a >> s) >= 64'h8000_0000 || (b >> s) >= 64'h8000_0000) s++;
      return s;
    endfunction

    function logic [63:0] ln16(logic [63:0] y);
      int k;
      logic [127:0] m;
      logic [63:0] fr, l2;
      k = 0;
      fr = 0;
      while (k < 63 && (y >> (k + 1)) != 0) k++;
      m = (k >= 30) ? (y >> (k - 30)) : (y << (30 - k));
      for (int i = 1; i <= LOG_FRAC; i++) begin
        m = (m * m) >> 30;
        if (m >= 128'h8000_0000) begin
          m >>= 1;
          fr |= 64'd1 << (LOG_FRAC - i);
        end
      end
      l2 = (64'(k - 16) << LOG_FRAC) | fr;
      return 64'((128'(l2) * LN2_Q32) >> 36);
    endfunction

    function logic [63:0] absv(logic signed [63:0] v);
      return v < 0 ? -v : v;
    endfunction

    // work out the residual of one accepted word
    function void note_word(corr_t w);
      logic signed [127:0] q [4], xx, yy, zz, xy, xz, yz, wx, wy, wz;
      logic signed [127:0] r00, r01, r02, r10, r11, r12, a, b, zu, zv;
      logic signed [127:0] xcu, xcv, al, du, dv, lam;
      logic [63:0] ua, ub, ra, rb, n, mu, mv, rad;
      int s;
      resid_t e;
      for (int i = 0; i < 4; i++) q[i] = w.f[5 + i];
      xx = fsr(q[0] * q[0], 29); yy = fsr(q[1] * q[1], 29); zz = fsr(q[2] * q[2], 29);
      xy = fsr(q[0] * q[1], 29); xz = fsr(q[0] * q[2], 29); yz = fsr(q[1] * q[2], 29);
      wx = fsr(q[3] * q[0], 29); wy = fsr(q[3] * q[1], 29); wz = fsr(q[3] * q[2], 29);
      r00 = clamp((128'sd1 <<< 30) - (yy + zz)); r01 = clamp(xy - wz);
      r02 = clamp(xz + wy); r10 = clamp(xy + wz);
      r11 = clamp((128'sd1 <<< 30) - (xx + zz)); r12 = clamp(yz - wx);
      a = fsr(r00 * w.f[2], 30) + fsr(r01 * w.f[3], 30) + fsr(r02 * w.f[4], 30) + w.f[9];
      b = fsr(r10 * w.f[2], 30) + fsr(r11 * w.f[3], 30) + fsr(r12 * w.f[4], 30) + w.f[10];
      ua = absv(a[63:0]); ub = absv(b[63:0]);
      s = scale31(ua, ub);
      ra = ua >> s; rb = ub >> s;
      n = root(ra * ra + rb * rb);
      e.dg = (n == 0);
      zu = 0; zv = 0;
      if (!e.dg) begin
        zu = (ra << 30) / n; if (a < 0) zu = -zu;
        zv = (rb << 30) / n; if (b < 0) zv = -zv;
      end
      xcu = w.f[0] - cu;
      xcv = w.f[1] - cv;
      al = fsr(zu * xcu + zv * xcv, 30);
      du = fsr(al * zu, 30) - xcu;
      dv = fsr(al * zv, 30) - xcv;
      mu = absv(xcu[63:0]); mv = absv(xcv[63:0]);
      s = scale31(mu, mv);
      rad = root((mu >> s) * (mu >> s) + (mv >> s) * (mv >> s)) << s;
      lam = ln16(rad + 64'h1_0000);
      e.ru = clamp(fsr(lam * du, 16));
      e.rv = clamp(fsr(lam * dv, 16));
      pending.insert(pending.size(), e);
    endfunction

    function void check_word(logic signed [31:0] ru, logic signed [31:0] rv, logic dg);
      resid_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (ru !== e.ru) begin
        $error("res_u expected %0d actual %0d", e.ru, ru); errors++;
      end
      if (rv !== e.rv) begin
        $error("res_v expected %0d actual %0d", e.rv, rv); errors++;
      end
      if (dg !== e.dg) begin
        $error("degenerate expected %0b actual %0b", e.dg, dg); errors++;
      end
    endfunction
  endclass

  localparam int N_RANDOM = 1930;
  localparam longint LIMIT = 2_000_000;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0, degenerate;
  logic signed [31:0] fld [11];
  logic signed [31:0] res_u, res_v;
  logic cfg_wen = 0, cfg_index = 0;
  logic [31:0] cfg_data = 0;
  longint cycles = 0;
  bit sending = 0, long_hold = 0;

  residual_scoreboard sb = new();

  initial for (int i = 0; i < 11; i++) fld[i] = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  radial_reprojection_residual uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .img_u(fld[0]), .img_v(fld[1]), .pt_x(fld[2]), .pt_y(fld[3]), .pt_z(fld[4]),
    .quat_x(fld[5]), .quat_y(fld[6]), .quat_z(fld[7]), .quat_w(fld[8]),
    .shift_x(fld[9]), .shift_y(fld[10]),
    .out_valid(out_valid), .out_stall(out_stall),
    .res_u(res_u), .res_v(res_v), .degenerate(degenerate),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data));

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // output side: check accepted words, random stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_word(res_u, res_v, degenerate);
    if (long_hold) out_stall <= 1;
    else if ($urandom_range(0, 9) < 7 || !sending) out_stall <= 0;
    else out_stall <= 1;
  end

  // long hold-off while the sender keeps going
  initial begin
    wait (sending);
    repeat (400) @(posedge clk);
    long_hold = 1;
    repeat (300) @(posedge clk);
    long_hold = 0;
  end

  function automatic logic signed [31:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 255)) - 128;
      3: return $signed($urandom) >>> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // random correspondence word, three in four with small fields and a Q2.30 quaternion
  function automatic corr_t rand_word();
    corr_t w;
    for (int i = 0; i < 11; i++) w.f[i] = rand_field();
    if ($urandom_range(0, 3) != 0) begin
      for (int i = 5; i < 9; i++) w.f[i] = $signed($urandom) >>> 2;
      for (int i = 0; i < 5; i++) w.f[i] = $signed($urandom) >>> $urandom_range(4, 16);
      w.f[9] = $signed($urandom) >>> 10;
      w.f[10] = $signed($urandom) >>> 10;
    end
    return w;
  endfunction

  // offer one word at this edge and hold it until accepted
  task automatic send_word(corr_t w);
    for (int i = 0; i < 11; i++) fld[i] <= w.f[i];
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(w);
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 40) : $urandom_range(1, 3))
        @(posedge clk);
    end
  endtask

  task automatic write_reg(logic idx, logic [31:0] d);
    @(posedge clk);
    cfg_wen <= 1; cfg_index <= idx; cfg_data <= d;
    @(posedge clk);
    cfg_wen <= 0;
    sb.set_centre(idx, d);
  endtask

  // wait until every expected word has arrived
  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (TOTAL_LAT + 10) @(posedge clk);
  endtask

  initial begin
    corr_t w;
    logic [31:0] centres [4];
    centres[0] = 32'h0;
    centres[1] = 32'h7fffffff;
    centres[2] = 32'h80000000;
    centres[3] = 32'h0140_0000;
    repeat (8) @(posedge clk);
    rst <= 0;
    sending = 1;
    // directed: extremes, identity, zero vector, non-unit quaternions, then random words
    for (int k = 0; k < 20; k++) begin
      for (int i = 0; i < 11; i++) w.f[i] = 0;
      w.f[8] = 32'sh4000_0000;
      case (k)
        0: ;
        1: begin w.f[0] = 32'sh0010_0000; w.f[2] = 32'sh0001_0000; end
        2: for (int i = 0; i < 11; i++) w.f[i] = 32'sh7fffffff;
        3: for (int i = 0; i < 11; i++) w.f[i] = 32'sh80000000;
        4: begin w.f[0] = 32'sh80000000; w.f[1] = 32'sh7fffffff; end
        5: begin w.f[9] = 32'sh0002_0000; w.f[10] = -32'sh0003_0000; w.f[0] = 32'sh0050_0000; end
        6: begin w.f[5] = 32'sh4000_0000; w.f[8] = 0; w.f[3] = 32'sh0001_0000; end
        7: begin w.f[8] = 0; w.f[0] = 32'sh1000_0000; end
        8: for (int i = 5; i < 9; i++) w.f[i] = 32'sh7fffffff;
        9: for (int i = 5; i < 9; i++) w.f[i] = 32'sh80000000;
        10: begin w.f[2] = 32'sh0001_0000; w.f[9] = -32'sh0001_0000; w.f[1] = 5; end
        default: w = rand_word();
      endcase
      send_word(w);
    end
    drain();
    // random phases under several centre settings
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_CENTER_U, centres[p]);
      write_reg(REG_CENTER_V, centres[3 - p]);
      for (int n = 0; n < N_RANDOM / 4; n++) send_word(rand_word());
      drain();
    end
    write_reg(REG_CENTER_U, $urandom);
    write_reg(REG_CENTER_V, $urandom);
    for (int n = 0; n < 30; n++) send_word(rand_word());
    drain();
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

@@ files.f @@
sv/rrr_pkg.sv
sv/rrr_front.sv
sv/rrr_isqrt.sv
sv/rrr_div.sv
sv/rrr_log.sv
sv/rrr_tail.sv
sv/radial_reprojection_residual.sv
tb/testbench.sv
